### rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the number beep announcer.
// Needs nothing else; the including file supplies clock, reset and the expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/nba_pkg.sv
// Package of the number beep announcer: types, reset values and helpers.
// Used by nba_cfg, nba_seq and the top level; depends on nothing.
`default_nettype none

package nba_pkg;

    // Widths fixed by the word formats
    localparam int unsigned CFG_WIDTH       = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned MAG_WIDTH       = 8;
    localparam int unsigned TENS_WIDTH      = 5;
    localparam int unsigned ONES_WIDTH      = 4;
    localparam int unsigned IN_DATA_WIDTH   = 16;
    localparam int unsigned OUT_DATA_WIDTH  = 8;

    // Default counter width
    localparam int unsigned TICK_COUNT_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] SHORT_BEEP_RESET = 16'd250;
    localparam logic [CFG_WIDTH-1:0] LONG_BEEP_RESET  = 16'd500;
    localparam logic [CFG_WIDTH-1:0] DIGIT_GAP_RESET  = 16'd500;

    // A ones digit of zero is sounded as ten beeps
    localparam logic [ONES_WIDTH-1:0] ONES_FOR_ZERO = 4'd10;
    localparam logic [MAG_WIDTH-1:0]  DIGIT_BASE    = 8'd10;

    // Register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SHORT_BEEP = 2'd0,
        CFG_LONG_BEEP  = 2'd1,
        CFG_DIGIT_GAP  = 2'd2
    } cfg_index_t;

    // Sequence phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_LONG_TONE = 6'b000010,
        PH_LONG_SIL  = 6'b000100,
        PH_BEEP      = 6'b001000,
        PH_SHORT_SIL = 6'b010000,
        PH_GAP       = 6'b100000
    } phase_t;

    // Durations held by the register bank
    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_ticks;
        logic [CFG_WIDTH-1:0] long_ticks;
        logic [CFG_WIDTH-1:0] gap_ticks;
    } cfg_t;

    // Result of one word
    typedef struct packed {
        logic done;
        logic busy;
        logic speaker;
    } result_t;

    // Tens digit of an 8-bit value: multiply by 205/2048, exact for every 8-bit input
    function automatic logic [TENS_WIDTH-1:0] div10(input logic [MAG_WIDTH-1:0] m);
        logic [15:0] prod;
        prod = 16'(m) * 16'd205;
        return prod[15:11];
    endfunction

endpackage

`default_nettype wire

### rtl/core/nba_cfg.sv
// Register bank of the number beep announcer: three tick durations.
// Depends on nba_pkg.
`default_nettype none

module nba_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [nba_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [nba_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    output nba_pkg::cfg_t                            cfg
);

    nba_pkg::cfg_t cfg_reg;

    // Decode the index and take the write; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks <= nba_pkg::SHORT_BEEP_RESET;
            cfg_reg.long_ticks  <= nba_pkg::LONG_BEEP_RESET;
            cfg_reg.gap_ticks   <= nba_pkg::DIGIT_GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (nba_pkg::cfg_index_t'(cfg_index))
                nba_pkg::CFG_SHORT_BEEP: cfg_reg.short_ticks <= cfg_wdata;
                nba_pkg::CFG_LONG_BEEP:  cfg_reg.long_ticks  <= cfg_wdata;
                nba_pkg::CFG_DIGIT_GAP:  cfg_reg.gap_ticks   <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/nba_seq.sv
// Sequencer of the number beep announcer: phase, digit counters, tick counter
// and speaker level, advanced by one word per step. Depends on nba_pkg.
`default_nettype none

module nba_seq #(
    parameter int unsigned TICK_COUNT_WIDTH = nba_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          mode,
    input  wire logic [nba_pkg::MAG_WIDTH-1:0] magnitude,
    input  wire logic                          negative,
    input  wire nba_pkg::cfg_t                 cfg,
    output nba_pkg::result_t                   res
);

    localparam int unsigned TW = TICK_COUNT_WIDTH;

    nba_pkg::phase_t                   phase_reg, phase_next;
    logic [nba_pkg::TENS_WIDTH-1:0]    tens_reg, tens_next;
    logic [nba_pkg::ONES_WIDTH-1:0]    ones_reg, ones_next;
    logic [TW-1:0]                     ticks_reg, ticks_next;
    logic                              spk_reg, spk_next;
    logic                              done;

    logic                              sounding;
    logic                              legal;
    logic [nba_pkg::TENS_WIDTH-1:0]    tens_in;
    logic [nba_pkg::MAG_WIDTH-1:0]     rem8;
    logic [nba_pkg::ONES_WIDTH-1:0]    ones_in;
    logic [nba_pkg::ONES_WIDTH-1:0]    ones_dec;
    logic [TW-1:0]                     ld_short, ld_long, ld_gap;

    // Split the start value into its digits
    assign tens_in = nba_pkg::div10(magnitude);
    assign rem8    = magnitude - nba_pkg::MAG_WIDTH'(tens_in * nba_pkg::DIGIT_BASE);
    assign ones_in = rem8[nba_pkg::ONES_WIDTH-1:0];

    // Durations fitted to the tick counter
    assign ld_short = TW'(cfg.short_ticks);
    assign ld_long  = TW'(cfg.long_ticks);
    assign ld_gap   = TW'(cfg.gap_ticks);

    assign sounding = (phase_reg == nba_pkg::PH_LONG_TONE) || (phase_reg == nba_pkg::PH_BEEP);
    assign legal    = (phase_reg == nba_pkg::PH_LONG_TONE) || (phase_reg == nba_pkg::PH_LONG_SIL)
                   || (phase_reg == nba_pkg::PH_BEEP) || (phase_reg == nba_pkg::PH_SHORT_SIL)
                   || (phase_reg == nba_pkg::PH_GAP);
    assign ones_dec = (ones_reg != '0) ? ones_reg - 1'b1 : '0;

    // Next state for the word in hand
    always_comb
    begin
        phase_next = phase_reg;
        tens_next  = tens_reg;
        ones_next  = ones_reg;
        ticks_next = ticks_reg;
        spk_next   = spk_reg;
        done       = 1'b0;
        if (mode)
        begin
            // Start: load digits and the first phase, ignored while busy
            if (phase_reg == nba_pkg::PH_IDLE)
            begin
                tens_next = tens_in;
                ones_next = (ones_in == '0) ? nba_pkg::ONES_FOR_ZERO : ones_in;
                spk_next  = 1'b0;
                if (negative)
                begin
                    phase_next = nba_pkg::PH_LONG_TONE;
                    ticks_next = ld_long;
                end
                else
                begin
                    phase_next = nba_pkg::PH_BEEP;
                    ticks_next = ld_short;
                end
            end
        end
        else if (phase_reg != nba_pkg::PH_IDLE)
        begin
            if (!legal)
            begin
                // Recover from a corrupted phase
                phase_next = nba_pkg::PH_IDLE;
                ticks_next = '0;
                spk_next   = 1'b0;
            end
            else
            begin
                if (sounding)
                begin
                    spk_next = ~spk_reg;
                end
                if (ticks_reg <= TW'(1))
                begin
                    // Phase ends: the speaker goes low whatever follows
                    ticks_next = '0;
                    spk_next   = 1'b0;
                    unique case (phase_reg)
                        nba_pkg::PH_LONG_TONE:
                        begin
                            phase_next = nba_pkg::PH_LONG_SIL;
                            ticks_next = ld_long;
                        end
                        nba_pkg::PH_LONG_SIL:
                        begin
                            phase_next = nba_pkg::PH_BEEP;
                            ticks_next = ld_short;
                        end
                        nba_pkg::PH_BEEP:
                        begin
                            phase_next = nba_pkg::PH_SHORT_SIL;
                            ticks_next = ld_short;
                        end
                        nba_pkg::PH_SHORT_SIL:
                        begin
                            if (tens_reg != '0)
                            begin
                                tens_next = tens_reg - 1'b1;
                                if (tens_reg != nba_pkg::TENS_WIDTH'(1))
                                begin
                                    phase_next = nba_pkg::PH_BEEP;
                                    ticks_next = ld_short;
                                end
                                else
                                begin
                                    phase_next = nba_pkg::PH_GAP;
                                    ticks_next = ld_gap;
                                end
                            end
                            else
                            begin
                                ones_next = ones_dec;
                                if (ones_dec != '0)
                                begin
                                    phase_next = nba_pkg::PH_BEEP;
                                    ticks_next = ld_short;
                                end
                                else
                                begin
                                    phase_next = nba_pkg::PH_GAP;
                                    ticks_next = ld_gap;
                                end
                            end
                        end
                        nba_pkg::PH_GAP:
                        begin
                            if (ones_reg != '0)
                            begin
                                phase_next = nba_pkg::PH_BEEP;
                                ticks_next = ld_short;
                            end
                            else
                            begin
                                phase_next = nba_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = nba_pkg::PH_IDLE;
                        end
                    endcase
                end
                else
                begin
                    ticks_next = ticks_reg - 1'b1;
                end
            end
        end
    end

    // Hold state between words, advance on a step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nba_pkg::PH_IDLE;
            tens_reg  <= '0;
            ones_reg  <= '0;
            ticks_reg <= '0;
            spk_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tens_reg  <= tens_next;
            ones_reg  <= ones_next;
            ticks_reg <= ticks_next;
            spk_reg   <= spk_next;
        end
    end

    assign res.speaker = spk_next;
    assign res.busy    = (phase_next != nba_pkg::PH_IDLE);
    assign res.done    = done;

endmodule

`default_nettype wire

### rtl/core/number_beep_announcer.sv
// Number beep announcer: sounds an 8-bit magnitude and a sign as beeps on a
// one-bit speaker, one time tick per input word.
//
// Channels: the slave side takes words whose tuser says tick (0) or start (1);
// tdata carries the magnitude and the sign, used by a start word only. The
// master side returns one word per input word with the speaker level, a busy
// flag and a done flag that is set on the tick that ends the last digit gap.
// The write port sets the three durations (short beep, long tone, digit gap)
// in ticks; write it only while no word is in flight.
// Path: an accepted word sits in the input register, and its result is taken
// into the result register once that register is free or being emptied.
// Throughput: one word per cycle while the master side takes results, as the
// phase and counter update between those registers is combinational.
// Reset: the sequence returns to idle, the speaker is low, both registers are
// empty and the durations take their default values.
// Stall: while the master side holds tready low a finished result stays put;
// one more word is still taken into an empty input register, after which tready
// on the slave side falls until the result is taken.
// Depends on nba_pkg, nba_cfg and nba_seq.
`default_nettype none

module number_beep_announcer #(
    parameter int unsigned TICK_COUNT_WIDTH = nba_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input words
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [nba_pkg::IN_DATA_WIDTH-1:0]   s_tdata,   // [7:0] magnitude, [8] negative
    input  wire logic                                s_tuser,   // [0] mode
    // Result words
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [nba_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,   // [0] speaker, [1] busy_res,
                                                                // [2] done_res
    // Register writes
    input  wire logic                                cfg_we,
    input  wire logic [nba_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [nba_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

    logic                            in_valid_reg, in_valid_next;
    logic                            in_mode_reg;
    logic [nba_pkg::MAG_WIDTH-1:0]   in_mag_reg;
    logic                            in_neg_reg;
    logic                            out_valid_reg, out_valid_next;
    nba_pkg::result_t                out_res_reg;
    logic                            step;
    logic                            s_fire;
    nba_pkg::cfg_t                   cfg;
    nba_pkg::result_t                res;

    // Process the held word when the result register is free or being emptied
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && !m_tready);

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_mode_reg <= s_tuser;
            in_mag_reg  <= s_tdata[nba_pkg::MAG_WIDTH-1:0];
            in_neg_reg  <= s_tdata[nba_pkg::MAG_WIDTH];
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    nba_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nba_seq #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .mode      (in_mode_reg),
        .magnitude (in_mag_reg),
        .negative  (in_neg_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.done, out_res_reg.busy, out_res_reg.speaker};

endmodule

`default_nettype wire

### rtl/core/nba_checker.sv
// Port checker of the number beep announcer, bound to the top level.
// Depends on assert_macros.svh and the top level's ports.
`default_nettype none
`include "assert_macros.svh"

module nba_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // The word that ends a sequence reports it no longer busy
    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, m_tvalid && m_tdata[2], !m_tdata[1], "done while busy")

    // The speaker is only driven during a running sequence
    `ASSERT_IMPL(a_spk_busy, clk, rst_n, m_tvalid && m_tdata[0], m_tdata[1], "speaker high while idle")

    // With the result register empty the input side never stalls
    `ASSERT_IMPL(a_ready_free, clk, rst_n, !m_tvalid, s_tready, "input stalled with no result waiting")

    // A stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

endmodule

bind number_beep_announcer nba_checker u_nba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/number_beep_announcer_tb.sv
// Self-checking bench for the number beep announcer: drives tick and start words,
// predicts speaker, busy and done per word and checks every result word.
// Depends on nba_pkg and number_beep_announcer.
`default_nettype none

module number_beep_announcer_tb;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Durations after reset and decimal split
    localparam logic [15:0] POR_SHORT_TICKS = 16'd250;
    localparam logic [15:0] POR_LONG_TICKS  = 16'd500;
    localparam logic [15:0] POR_GAP_TICKS   = 16'd500;
    localparam int unsigned DECIMAL         = 10;
    localparam logic [3:0]  ZERO_ONES_BEEPS = 4'd10;

    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 40;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 80;

    logic clk;
    logic rst_n = 1'b0;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [nba_pkg::IN_DATA_WIDTH-1:0]  s_tdata  = '0;
    logic                               s_tuser  = MODE_TICK;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [nba_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
    logic                               cfg_we    = 1'b0;
    nba_pkg::cfg_index_t                cfg_index = nba_pkg::CFG_SHORT_BEEP;
    logic [nba_pkg::CFG_WIDTH-1:0]      cfg_wdata = '0;

    number_beep_announcer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predicted durations and sequence state
    logic [15:0]      short_ticks = POR_SHORT_TICKS;
    logic [15:0]      long_ticks  = POR_LONG_TICKS;
    logic [15:0]      gap_ticks   = POR_GAP_TICKS;
    nba_pkg::phase_t  seq_phase   = nba_pkg::PH_IDLE;
    logic [4:0]       tens_due    = '0;
    logic [3:0]       ones_due    = '0;
    logic [15:0]      ticks_due   = '0;
    logic             spk_level   = 1'b0;
    logic             tone_on     = 1'b0;

    nba_pkg::result_t announce_due [$];
    int               fault_count = 0;
    int               burst_left  = 0;
    int               idle_cycles = 0;

    function automatic void enter_phase(input nba_pkg::phase_t p, input logic [15:0] dur);
        seq_phase = p;
        ticks_due = dur;
        tone_on   = (p == nba_pkg::PH_LONG_TONE) || (p == nba_pkg::PH_BEEP);
        spk_level = 1'b0;
    endfunction

    // Advance the announcer by one word and return the speaker, busy and done it shows
    function automatic nba_pkg::result_t announce_step(input logic md, input logic [7:0] mag,
                                                       input logic ng);
        nba_pkg::result_t r;
        logic             fin;
        fin = 1'b0;
        if (md == MODE_START)
        begin
            // a start while busy is dropped
            if (seq_phase == nba_pkg::PH_IDLE)
            begin
                tens_due = 5'(mag / DECIMAL);
                ones_due = 4'(mag % DECIMAL);
                if (ones_due == 0)
                    ones_due = ZERO_ONES_BEEPS;
                if (ng)
                    enter_phase(nba_pkg::PH_LONG_TONE, long_ticks);
                else
                    enter_phase(nba_pkg::PH_BEEP, short_ticks);
            end
        end
        else if (seq_phase != nba_pkg::PH_IDLE)
        begin
            if (tone_on)
                spk_level = ~spk_level;
            // a count of zero ends the phase on its first tick, like one
            if (ticks_due > 16'd1)
                ticks_due = ticks_due - 16'd1;
            else
            begin
                ticks_due = '0;
                case (seq_phase)
                    nba_pkg::PH_LONG_TONE: enter_phase(nba_pkg::PH_LONG_SIL, long_ticks);
                    nba_pkg::PH_LONG_SIL:  enter_phase(nba_pkg::PH_BEEP, short_ticks);
                    nba_pkg::PH_BEEP:      enter_phase(nba_pkg::PH_SHORT_SIL, short_ticks);
                    nba_pkg::PH_SHORT_SIL:
                    begin
                        if (tens_due != 0)
                        begin
                            tens_due = tens_due - 5'd1;
                            if (tens_due != 0)
                                enter_phase(nba_pkg::PH_BEEP, short_ticks);
                            else
                                enter_phase(nba_pkg::PH_GAP, gap_ticks);
                        end
                        else
                        begin
                            if (ones_due != 0)
                                ones_due = ones_due - 4'd1;
                            if (ones_due != 0)
                                enter_phase(nba_pkg::PH_BEEP, short_ticks);
                            else
                                enter_phase(nba_pkg::PH_GAP, gap_ticks);
                        end
                    end
                    nba_pkg::PH_GAP:
                    begin
                        if (ones_due != 0)
                            enter_phase(nba_pkg::PH_BEEP, short_ticks);
                        else
                        begin
                            enter_phase(nba_pkg::PH_IDLE, 16'd0);
                            fin = 1'b1;
                        end
                    end
                    default: enter_phase(nba_pkg::PH_IDLE, 16'd0);
                endcase
            end
        end
        r.speaker = spk_level;
        r.busy    = (seq_phase != nba_pkg::PH_IDLE);
        r.done    = fin;
        return r;
    endfunction

    // Offer one word, hold it until taken, then log what it should produce
    task automatic push_word(input logic md, input logic [7:0] mag, input logic ng,
                             input logic typed, input logic [2:0] want);
        nba_pkg::result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= nba_pkg::IN_DATA_WIDTH'({ng, mag});
        do
            @(posedge clk);
        while (!s_tready);
        r = announce_step(md, mag, ng);
        // typed rows override the predictor with the value read off by hand
        if (typed)
            r = nba_pkg::result_t'(want);
        announce_due.push_back(r);
    endtask

    // Send in bursts of random length separated by random gaps
    task automatic send_paced(input logic md, input logic [7:0] mag, input logic ng,
                              input logic typed, input logic [2:0] want);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        push_word(md, mag, ng, typed, want);
    endtask

    // Hold off until every result has come back, then let the pipeline settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (announce_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_durations(input logic [15:0] sh, input logic [15:0] lg,
                                 input logic [15:0] gp);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= nba_pkg::CFG_SHORT_BEEP;
        cfg_wdata <= sh;
        @(posedge clk);
        cfg_index <= nba_pkg::CFG_LONG_BEEP;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_index <= nba_pkg::CFG_DIGIT_GAP;
        cfg_wdata <= gp;
        @(posedge clk);
        cfg_we      <= 1'b0;
        short_ticks = sh;
        long_ticks  = lg;
        gap_ticks   = gp;
    endtask

    // Tick until the announcement finishes; unused fields carry noise
    task automatic run_out_sequence();
        while (seq_phase != nba_pkg::PH_IDLE)
            send_paced(MODE_TICK, 8'($urandom), 1'($urandom), 1'b0, 3'b000);
    endtask

    function automatic logic [7:0] random_magnitude();
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(0, 29));
            2:       return 8'($urandom_range(0, 255));
            default:
                case ($urandom_range(0, 5))
                    0:       return 8'd0;
                    1:       return 8'd9;
                    2:       return 8'd10;
                    3:       return 8'd99;
                    4:       return 8'd100;
                    default: return 8'd255;
                endcase
        endcase
    endfunction

    // Directed words; want is {done, busy, speaker}
    typedef struct packed {
        logic        new_cfg;
        logic [15:0] sh;
        logic [15:0] lg;
        logic [15:0] gp;
        logic        md;
        logic [7:0]  mag;
        logic        ng;
        logic        typed;
        logic [2:0]  want;
        logic        run_out;
    } probe_row_t;

    localparam int DIR_ROWS = 19;

    probe_row_t probe_tab [DIR_ROWS] = '{
        // reset durations: idle tick, start, start while busy, first beep ticks;
        // the durations shrink mid-beep and the beep runs out its loaded count
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b000, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd1,   1'b0, 1'b1, 3'b010, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd200, 1'b0, 1'b1, 3'b010, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b011, 1'b0},
        '{1'b1, 16'd1, 16'd1, 16'd1, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b010, 1'b1},
        // one-tick phases: a single beep through to done
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd1,   1'b0, 1'b1, 3'b010, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b010, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b010, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b100, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_TICK,  8'd0,   1'b0, 1'b1, 3'b000, 1'b0},
        // zero ones digit, largest value, tens only, ones only
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd0,   1'b0, 1'b1, 3'b010, 1'b1},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd255, 1'b1, 1'b1, 3'b010, 1'b1},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd10,  1'b0, 1'b0, 3'b000, 1'b1},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd9,   1'b1, 1'b0, 3'b000, 1'b1},
        // durations of zero behave as one; then small unequal durations
        '{1'b1, 16'd0, 16'd0, 16'd0, MODE_START, 8'd37,  1'b1, 1'b0, 3'b000, 1'b1},
        '{1'b1, 16'd2, 16'd3, 16'd4, MODE_START, 8'd100, 1'b0, 1'b0, 3'b000, 1'b1},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd128, 1'b1, 1'b0, 3'b000, 1'b0},
        '{1'b0, 16'd0, 16'd0, 16'd0, MODE_START, 8'd85,  1'b0, 1'b1, 3'b010, 1'b1},
        // longer, unequal durations on every phase
        '{1'b1, 16'd12, 16'd16, 16'd9, MODE_START, 8'd1, 1'b1, 1'b1, 3'b010, 1'b1}
    };

    // Receiver: ready follows a 16-bit pattern, redrawn each time the 7-bit age counter wraps
    logic [15:0] stall_pat = 16'hFFFF;
    logic [6:0]  pat_age   = '0;

    always @(posedge clk)
    begin
        if (pat_age == 0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        pat_age  <= pat_age + 7'd1;
        m_tready <= stall_pat[pat_age[3:0]];
    end

    task automatic flag_mismatch(input string what, input logic exp_v, input logic act_v);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, exp_v, act_v);
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        nba_pkg::result_t got;
        nba_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = nba_pkg::result_t'(m_tdata[2:0]);
            if (announce_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got %b",
                             $time, got);
            end
            else
            begin
                want = announce_due.pop_front();
                if (got.speaker !== want.speaker)
                    flag_mismatch("speaker", want.speaker, got.speaker);
                if (got.busy !== want.busy)
                    flag_mismatch("busy", want.busy, got.busy);
                if (got.done !== want.done)
                    flag_mismatch("done", want.done, got.done);
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int phase_no;
        int counted;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (probe_tab[i])
        begin
            if (probe_tab[i].new_cfg)
                set_durations(probe_tab[i].sh, probe_tab[i].lg, probe_tab[i].gp);
            send_paced(probe_tab[i].md, probe_tab[i].mag, probe_tab[i].ng,
                       probe_tab[i].typed, probe_tab[i].want);
            if (probe_tab[i].run_out)
                run_out_sequence();
        end

        // Random phases: mostly whole announcements, with stray starts and idle ticks
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            set_durations(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                          16'($urandom_range(1, 5)));
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                if (seq_phase == nba_pkg::PH_IDLE)
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        send_paced(MODE_START, random_magnitude(), 1'($urandom), 1'b0, 3'b000);
                        counted++;
                    end
                    else
                        send_paced(MODE_TICK, 8'($urandom), 1'($urandom), 1'b0, 3'b000);
                end
                else if ($urandom_range(0, 19) == 0)
                    send_paced(MODE_START, random_magnitude(), 1'($urandom), 1'b0, 3'b000);
                else
                begin
                    send_paced(MODE_TICK, 8'($urandom), 1'($urandom), 1'b0, 3'b000);
                    counted++;
                end
                // now and then drain mid-sequence
                if ($urandom_range(0, 299) == 0)
                    quiesce();
            end
            run_out_sequence();
        end

        quiesce();
        if (fault_count == 0 && announce_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/nba_pkg.sv
rtl/core/nba_cfg.sv
rtl/core/nba_seq.sv
rtl/core/number_beep_announcer.sv
rtl/core/nba_checker.sv
bench/number_beep_announcer_tb.sv
